### src/cipa_pkg.sv
// shared constants and types for the cached id pool allocator
`timescale 1ns / 1ps

package cipa_pkg;

    localparam int MaxUsers   = 8;
    localparam int CacheDepth = 32;
    localparam int MaxIds     = 1024;

    localparam int UserW  = $clog2(MaxUsers);
    localparam int CPtrW  = $clog2(CacheDepth);
    localparam int CFillW = CPtrW + 1;
    localparam int FPtrW  = $clog2(MaxIds);
    localparam int FFillW = FPtrW + 1;
    localparam int CAddrW = UserW + CPtrW;

    // register indexes
    localparam logic [1:0] REG_USER_COUNT = 2'd0;
    localparam logic [1:0] REG_ID_BASE    = 2'd1;
    localparam logic [1:0] REG_ID_COUNT   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ALLOC    = 3'd0;
    localparam logic [2:0] ST_EXHAUST  = 3'd1;
    localparam logic [2:0] ST_FREED    = 3'd2;
    localparam logic [2:0] ST_FLUSHED  = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic [31:0] id;
        logic [2:0]  status;
        logic        granted;
    } cipa_result_t;

endpackage

### src/cipa_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module cipa_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/cached_id_pool_allocator.sv
// Cached id pool allocator: one request beat in, one result beat out, one request at a time.
// The user index is first reduced modulo the user count by eight compare and subtract steps,
// one per cycle. A refill moves ids from the shared free list, each through a wait state and
// a write state (read through its ram port), then one fresh id per cycle. A steal checks the
// own cache and then every user in index order, one per cycle. A flush moves the cache to the
// free list, each id through a wait state and a data state.
// The next request is taken once the result beat has been accepted.
`timescale 1ns / 1ps

module cached_id_pool_allocator
    import cipa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func, user[7:0], id_value[31:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // granted, out_id[31:0], status[2:0], zero pad
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_POP    = 4'd2;
    localparam logic [3:0] S_RFREE  = 4'd3;
    localparam logic [3:0] S_RWAIT  = 4'd4;
    localparam logic [3:0] S_RFRESH = 4'd5;
    localparam logic [3:0] S_STEAL  = 4'd6;
    localparam logic [3:0] S_FLUSH  = 4'd7;
    localparam logic [3:0] S_FWAIT  = 4'd8;
    localparam logic [3:0] S_FDATA  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_MOD    = 4'd11;

    // configuration registers
    logic [3:0]  user_count_reg;
    logic [31:0] id_base_reg;
    logic [10:0] id_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_count_reg <= 4'd1;
            id_base_reg    <= 32'd0;
            id_count_reg   <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_USER_COUNT: user_count_reg <= cfg_data[3:0];
                REG_ID_BASE:    id_base_reg    <= cfg_data;
                REG_ID_COUNT:   id_count_reg   <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    logic [UserW:0]  users;
    logic [FFillW-1:0] eff_count;
    always_comb
    begin
        if (user_count_reg == 4'd0)
            users = (UserW+1)'(1);
        else if (user_count_reg > 4'(MaxUsers))
            users = (UserW+1)'(MaxUsers);
        else
            users = user_count_reg[UserW:0];
        eff_count = (id_count_reg > 11'(MaxIds)) ? FFillW'(MaxIds) : id_count_reg;
    end

    // control state
    logic [3:0]        state_reg, state_next;
    logic [CPtrW-1:0]  chead_reg [MaxUsers];
    logic [CFillW-1:0] cfill_reg [MaxUsers];
    logic [FPtrW-1:0]  fhead_reg;
    logic [FFillW-1:0] ffill_reg;
    logic [10:0]       fresh_reg;
    logic              func_reg;
    logic [7:0]        ureq_reg;   // user index, reduced in place
    logic [2:0]        mod_k_reg;
    logic [UserW-1:0]  u_reg;
    logic [UserW:0]    scan_reg;
    logic [UserW-1:0]  pu_reg;   // user whose cache is being popped
    logic [31:0]       idv_reg;
    logic              lost_reg;
    logic              m_valid_reg;
    cipa_result_t      res_reg;

    // ram ports
    logic              c_we, f_we;
    logic [CAddrW-1:0] c_waddr, c_raddr;
    logic [31:0]       c_wdata, c_rdata, f_wdata, f_rdata;
    logic [FPtrW-1:0]  f_waddr, f_raddr;

    cipa_ram #(.Width(32), .Depth(MaxUsers*CacheDepth)) u_cache_ram (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    cipa_ram #(.Width(32), .Depth(MaxIds)) u_free_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    logic accept;
    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, res_reg.status, res_reg.id, res_reg.granted};

    // helper values
    logic [CFillW-1:0] fill_u;
    logic [CPtrW-1:0]  head_u, tail_u;
    logic [32:0]       hi_bound;
    logic              in_range;
    logic [FPtrW-1:0]  ftail;
    logic [2:0]        dec_status;
    assign fill_u   = cfill_reg[u_reg];
    assign head_u   = chead_reg[u_reg];
    assign tail_u   = head_u + fill_u[CPtrW-1:0];
    assign hi_bound = {1'b0, id_base_reg} + 33'(eff_count);
    assign in_range = ({1'b0, idv_reg} < hi_bound) && (idv_reg >= id_base_reg);
    assign ftail    = fhead_reg + ffill_reg[FPtrW-1:0];
    assign dec_status = (func_reg == FUNC_ALLOC) ? ST_EXHAUST
                      : !in_range ? ST_RANGE
                      : (fill_u != CFillW'(CacheDepth)) ? ST_FREED : ST_EXHAUST;

    // one compare and subtract step of the user index reduction
    logic [11:0] mod_sub;
    logic [7:0]  rem_step;
    assign mod_sub  = 12'(users) << mod_k_reg;
    assign rem_step = ({4'd0, ureq_reg} >= mod_sub) ? ureq_reg - mod_sub[7:0] : ureq_reg;

    // cache read address follows the popping user's head
    assign c_raddr = {pu_reg, chead_reg[pu_reg]};
    assign f_raddr = fhead_reg;

    always_comb
    begin
        state_next = state_reg;
        c_we = 1'b0; c_waddr = {u_reg, tail_u}; c_wdata = idv_reg;
        f_we = 1'b0; f_waddr = ftail; f_wdata = idv_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_MOD;
            S_MOD:    if (mod_k_reg == 3'd0) state_next = S_DEC;
            S_DEC:
            begin
                if (func_reg == FUNC_ALLOC)
                    state_next = (fill_u != '0) ? S_POP
                               : (ffill_reg != '0) ? S_RWAIT : S_RFRESH;
                else if (!in_range)
                    state_next = S_DONE;
                else if (fill_u != CFillW'(CacheDepth))
                begin
                    c_we = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_FWAIT;
            end
            S_POP:    state_next = S_DONE;
            S_RWAIT:  state_next = S_RFREE;
            S_RFREE:
            begin
                c_we = 1'b1;
                c_wdata = f_rdata;
                if (ffill_reg == FFillW'(1) || fill_u == CFillW'(CacheDepth - 1))
                    state_next = S_RFRESH;
                else
                    state_next = S_RWAIT;
            end
            S_RFRESH:
            begin
                if ({5'd0, fresh_reg} < 16'(eff_count) && fill_u != CFillW'(CacheDepth))
                begin
                    c_we = 1'b1;
                    c_wdata = id_base_reg + 32'(fresh_reg);
                end
                else
                    state_next = S_STEAL;
            end
            S_STEAL:
            begin
                if (cfill_reg[pu_reg] != '0)
                    state_next = S_POP;
                else if (scan_reg >= users)
                    state_next = S_DONE;
            end
            S_FWAIT:  state_next = S_FDATA;
            S_FDATA:
            begin
                f_wdata = c_rdata;
                f_we = (ffill_reg != FFillW'(MaxIds));
                state_next = (fill_u == CFillW'(1)) ? S_FLUSH : S_FWAIT;
            end
            S_FLUSH:
            begin
                f_we = (ffill_reg != FFillW'(MaxIds));
                state_next = S_DONE;
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fhead_reg   <= '0;
            ffill_reg   <= '0;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
            u_reg       <= '0;
            pu_reg      <= '0;
            scan_reg    <= '0;
            mod_k_reg   <= '0;
            lost_reg    <= 1'b0;
            func_reg    <= FUNC_ALLOC;
            for (int i = 0; i < MaxUsers; i++)
            begin
                chead_reg[i] <= '0;
                cfill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg  <= s_tdata[0];
                        ureq_reg  <= s_tdata[8:1];
                        idv_reg   <= s_tdata[40:9];
                        mod_k_reg <= 3'd7;
                    end
                end
                S_MOD:
                begin
                    ureq_reg  <= rem_step;
                    mod_k_reg <= mod_k_reg - 1'b1;
                    if (mod_k_reg == 3'd0)
                    begin
                        u_reg  <= rem_step[UserW-1:0];
                        pu_reg <= rem_step[UserW-1:0];
                    end
                end
                S_DEC:
                begin
                    lost_reg <= 1'b0;
                    res_reg  <= '{id: 32'd0, status: dec_status, granted: 1'b0};
                    if (func_reg == FUNC_FREE && in_range && fill_u != CFillW'(CacheDepth))
                        cfill_reg[u_reg] <= fill_u + 1'b1;
                end
                S_POP:
                begin
                    chead_reg[pu_reg] <= chead_reg[pu_reg] + 1'b1;
                    cfill_reg[pu_reg] <= cfill_reg[pu_reg] - 1'b1;
                end
                S_RFREE:
                begin
                    cfill_reg[u_reg] <= fill_u + 1'b1;
                    fhead_reg <= fhead_reg + 1'b1;
                    ffill_reg <= ffill_reg - 1'b1;
                end
                S_RFRESH:
                begin
                    if ({5'd0, fresh_reg} < 16'(eff_count) && fill_u != CFillW'(CacheDepth))
                    begin
                        cfill_reg[u_reg] <= fill_u + 1'b1;
                        fresh_reg <= fresh_reg + 1'b1;
                    end
                    else
                    begin
                        scan_reg <= '0;
                        pu_reg   <= u_reg;
                    end
                end
                S_STEAL:
                begin
                    // move on to the next user in index order
                    if (cfill_reg[pu_reg] == '0 && scan_reg < users)
                    begin
                        pu_reg   <= scan_reg[UserW-1:0];
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_FDATA:
                begin
                    chead_reg[u_reg] <= head_u + 1'b1;
                    cfill_reg[u_reg] <= fill_u - 1'b1;
                    if (ffill_reg != FFillW'(MaxIds))
                        ffill_reg <= ffill_reg + 1'b1;
                    else
                        lost_reg <= 1'b1;
                end
                S_FLUSH:
                begin
                    if (ffill_reg != FFillW'(MaxIds))
                    begin
                        ffill_reg <= ffill_reg + 1'b1;
                        res_reg.status <= lost_reg ? ST_OVERFLOW : ST_FLUSHED;
                    end
                    else
                        res_reg.status <= ST_OVERFLOW;
                end
                S_DONE:   m_valid_reg <= 1'b1;
                default: ;
            endcase
            // grant once pop data is back
            if (state_reg == S_POP)
            begin
                res_reg <= '{id: c_rdata, status: ST_ALLOC, granted: 1'b1};
            end
        end
    end

endmodule

### src/cipa_checker.sv
// port-level checks for the cached id pool allocator, bound to the top level
`timescale 1ns / 1ps

module cipa_checker
    import cipa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // no new request while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("request taken while result pending");

    // granted results report allocated status
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[35:33] == ST_ALLOC)
        else $error("grant with wrong status");

    // refused results carry a zero id
    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("nonzero id without grant");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

endmodule

bind cached_id_pool_allocator cipa_checker u_cipa_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### test/testbench.sv
// self-checking testbench for the cached id pool allocator
`timescale 1ns / 1ps

module testbench;
    import cipa_pkg::*;

    localparam int StallLimit = 5000;
    localparam int SettleCycles = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_USER_COUNT;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // func, user[7:0], id_value[31:0], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // granted, out_id[31:0], status[2:0], zero pad

    cached_id_pool_allocator dut (.*);

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow copy of the allocator state
    logic [3:0]  sh_users;
    logic [31:0] sh_base;
    logic [10:0] sh_count;
    logic [31:0] sh_cache [MaxUsers][CacheDepth];
    int          sh_chead [MaxUsers];
    int          sh_cfill [MaxUsers];
    logic [31:0] sh_free [MaxIds];
    int          sh_fhead;
    int          sh_ffill;
    int          sh_fresh;

    cipa_result_t expected_results [$];
    logic [31:0]  held_ids [$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_overflow = 0;
    int n_flush = 0;
    int n_exhaust = 0;
    bit calm = 1'b0;
    int stall_cycles = 0;

    function automatic int users_now();
        if (sh_users == 0) return 1;
        if (sh_users > MaxUsers) return MaxUsers;
        return sh_users;
    endfunction

    function automatic int count_now();
        return (sh_count > MaxIds) ? MaxIds : sh_count;
    endfunction

    function automatic bit cache_take(int u, output logic [31:0] v);
        v = '0;
        if (sh_cfill[u] == 0) return 1'b0;
        v = sh_cache[u][sh_chead[u]];
        sh_chead[u] = (sh_chead[u] + 1) % CacheDepth;
        sh_cfill[u]--;
        return 1'b1;
    endfunction

    function automatic void cache_put(int u, logic [31:0] v);
        sh_cache[u][(sh_chead[u] + sh_cfill[u]) % CacheDepth] = v;
        sh_cfill[u]++;
    endfunction

    function automatic bit free_put(logic [31:0] v);
        if (sh_ffill >= MaxIds) return 1'b0;
        sh_free[(sh_fhead + sh_ffill) % MaxIds] = v;
        sh_ffill++;
        return 1'b1;
    endfunction

    // computes the result of one request and updates the shadow state
    function automatic cipa_result_t allocate_or_free(logic fn, logic [7:0] usr,
                                                      logic [31:0] idv);
        cipa_result_t r;
        int u;
        logic [31:0] v;
        logic [32:0] lo;
        logic [32:0] hi;
        bit lost;
        r = '0;
        u = usr % users_now();
        if (fn == FUNC_ALLOC) begin
            if (cache_take(u, v)) r.granted = 1'b1;
            else
            begin
                while (sh_ffill > 0 && sh_cfill[u] < CacheDepth) begin
                    cache_put(u, sh_free[sh_fhead]);
                    sh_fhead = (sh_fhead + 1) % MaxIds;
                    sh_ffill--;
                end
                while (sh_fresh < count_now() && sh_cfill[u] < CacheDepth) begin
                    cache_put(u, sh_base + 32'(sh_fresh));
                    sh_fresh++;
                end
                if (cache_take(u, v)) r.granted = 1'b1;
                else
                begin
                    for (int i = 0; i < users_now(); i++) begin
                        if (i != u && cache_take(i, v))
                        begin
                            r.granted = 1'b1;
                            break;
                        end
                    end
                end
            end
            r.id = r.granted ? v : '0;
            r.status = r.granted ? ST_ALLOC : ST_EXHAUST;
        end
        else
        begin
            lo = {1'b0, sh_base};
            hi = lo + 33'(count_now());
            if ({1'b0, idv} < lo || {1'b0, idv} >= hi) r.status = ST_RANGE;
            else if (sh_cfill[u] < CacheDepth)
            begin
                cache_put(u, idv);
                r.status = ST_FREED;
            end
            else
            begin
                lost = 1'b0;
                while (cache_take(u, v))
                    if (!free_put(v)) lost = 1'b1;
                if (!free_put(idv)) lost = 1'b1;
                r.status = lost ? ST_OVERFLOW : ST_FLUSHED;
            end
        end
        return r;
    endfunction

    // random idling on the result side
    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);

    // result checker
    always @(posedge clk)
    begin
        cipa_result_t got;
        cipa_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.granted = m_tdata[0];
            got.id = m_tdata[32:1];
            got.status = m_tdata[35:33];
            n_results++;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", m_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.granted !== want.granted || got.id !== want.id
                    || got.status !== want.status || m_tdata[39:36] !== 4'b0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected g=%0d id=%h st=%0d got g=%0d id=%h st=%0d",
                                 want.granted, want.id, want.status,
                                 got.granted, got.id, got.status);
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sends one request beat; a typed expectation replaces the predicted one
    task automatic send(logic fn, logic [7:0] usr, logic [31:0] idv,
                        bit typed = 1'b0, cipa_result_t typed_res = '0);
        cipa_result_t r;
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, idv, usr, fn};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        r = allocate_or_free(fn, usr, idv);
        n_items++;
        if (r.status == ST_OVERFLOW) n_overflow++;
        if (r.status == ST_FLUSHED) n_flush++;
        if (r.status == ST_EXHAUST) n_exhaust++;
        if (r.granted) held_ids.push_back(r.id);
        expected_results.push_back(typed ? typed_res : r);
        if (!calm && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_USER_COUNT) sh_users = val[3:0];
        else if (idx == REG_ID_BASE) sh_base = val;
        else sh_count = val[10:0];
        @(posedge clk);
    endtask

    // one random request: mostly allocs and frees of held ids, some noise
    task automatic random_request();
        int k;
        logic [31:0] idv;
        logic [7:0] usr;
        usr = $urandom_range(255);
        k = $urandom_range(99);
        if (k < 50) send(FUNC_ALLOC, usr, $urandom);
        else
        begin
            if (k < 80 && held_ids.size() != 0)
            begin
                k = $urandom_range(held_ids.size() - 1);
                idv = held_ids[k];
                held_ids.delete(k);
            end
            else if (k < 92 && count_now() != 0)
                idv = sh_base + 32'($urandom_range(count_now() - 1));
            else idv = $urandom;
            send(FUNC_FREE, usr, idv);
        end
    endtask

    task automatic run_phase(logic [31:0] users, logic [31:0] base, logic [31:0] cnt,
                             int n);
        write_reg(REG_USER_COUNT, users);
        write_reg(REG_ID_BASE, base);
        write_reg(REG_ID_COUNT, cnt);
        held_ids.delete();
        for (int i = 0; i < n; i++) begin
            calm = (i >= n / 3 && i < n / 2);
            random_request();
        end
        calm = 1'b0;
        drain();
    endtask

    typedef struct {
        logic         fn;
        logic [7:0]   usr;
        logic [31:0]  idv;
        bit           typed;
        cipa_result_t res;
    } request_row_t;

    request_row_t directed [] = '{
        '{FUNC_ALLOC, 8'd0,   32'd0,          1'b1, '{32'd0, ST_ALLOC, 1'b1}},
        '{FUNC_ALLOC, 8'd255, 32'hFFFF_FFFF,  1'b1, '{32'd1, ST_ALLOC, 1'b1}},
        '{FUNC_FREE,  8'd0,   32'd1024,       1'b1, '{32'd0, ST_RANGE, 1'b0}},
        '{FUNC_FREE,  8'd7,   32'hFFFF_FFFF,  1'b1, '{32'd0, ST_RANGE, 1'b0}},
        '{FUNC_FREE,  8'd0,   32'd0,          1'b1, '{32'd0, ST_FREED, 1'b0}},
        '{FUNC_FREE,  8'd128, 32'd1023,       1'b1, '{32'd0, ST_FREED, 1'b0}},
        '{FUNC_ALLOC, 8'd3,   32'd0,          1'b0, '{32'd0, ST_ALLOC, 1'b0}},
        '{FUNC_ALLOC, 8'd0,   32'h5555_5555,  1'b0, '{32'd0, ST_ALLOC, 1'b0}},
        '{FUNC_FREE,  8'd1,   32'd2,          1'b0, '{32'd0, ST_ALLOC, 1'b0}},
        '{FUNC_FREE,  8'd2,   32'hAAAA_AAAA,  1'b0, '{32'd0, ST_ALLOC, 1'b0}}
    };

    initial
    begin
        sh_users = 4'd1;
        sh_base = '0;
        sh_count = 11'd1024;
        sh_fresh = 0;
        sh_fhead = 0;
        sh_ffill = 0;
        for (int u = 0; u < MaxUsers; u++) begin
            sh_chead[u] = 0;
            sh_cfill[u] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests at reset settings
        foreach (directed[i])
            send(directed[i].fn, directed[i].usr, directed[i].idv,
                 directed[i].typed, directed[i].res);
        drain();

        // fill the shared free list past its end: prime all caches, flush them,
        // then keep freeing into user zero
        write_reg(REG_USER_COUNT, 32'd8);
        write_reg(REG_ID_BASE, 32'd0);
        write_reg(REG_ID_COUNT, 32'd1024);
        for (int v = 1; v < MaxUsers; v++)
            send(FUNC_ALLOC, 8'(v), 32'd0);
        for (int v = 0; v < MaxUsers; v++)
            repeat (2) send(FUNC_FREE, 8'(v), 32'($urandom_range(1023)));
        for (int i = 0; i < 810; i++) begin
            calm = (i >= 200 && i < 500);
            send(FUNC_FREE, 8'(8 * $urandom_range(31)), 32'($urandom_range(1023)));
        end
        calm = 1'b0;
        drain();

        // settings sweep, extremes included
        run_phase(32'd8, 32'd0, 32'd300, 20);
        run_phase(32'd0, 32'd5000, 32'd40, 12);
        run_phase(32'd15, 32'hFFFF_FFF0, 32'd100, 12);
        run_phase(32'd3, 32'h8000_0000, 32'd0, 8);
        run_phase(32'd5, 32'd0, 32'd2047, 15);

        $display("covered %0d requests, %0d results: %0d flushes, %0d overflows, %0d exhausted",
                 n_items, n_results, n_flush, n_overflow, n_exhaust);
        if (errors == 0 && expected_results.size() == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

### cached_id_pool_allocator.f
src/cipa_pkg.sv
src/cipa_ram.sv
src/cached_id_pool_allocator.sv
src/cipa_checker.sv
test/testbench.sv
